FILE: hw/rtl/uvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, register codes, the CORDIC angle table and a small helper
// for the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int SEG_W    = 9;
    localparam int TEX_W    = 17;
    localparam int IDX_W    = 17;
    localparam int POS_W    = 16;
    localparam int ANG_W    = 32;
    localparam int TRIG_W   = 32;
    localparam int PROD_W   = 64;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int DEF_MAX_SEGMENTS  = 256;
    localparam int DEF_FRACTION_BITS = 16;

    // Fraction bits produced by the divider chain: enough for a full binary angle.
    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 24;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;

    localparam logic [31:0] ANGLE_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic {
        REG_X_SEGMENTS = 1'b0,
        REG_Y_SEGMENTS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic             face_valid;
        logic [IDX_W-1:0] corner_a;
        logic [IDX_W-1:0] corner_b;
        logic [IDX_W-1:0] corner_c;
        logic [IDX_W-1:0] corner_d;
    } t_side;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } t_tex;

    // Saturate a rounded value to signed Q1.15.
    function automatic logic [POS_W-1:0] sat_q15(input logic signed [PROD_W-1:0] v);
        logic [POS_W-1:0] res;
        if (v > 64'sd32767) begin
            res = 16'h7FFF;
        end else if (v < -64'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage : uvs_pkg
`default_nettype wire

FILE: hw/rtl/uv_sphere_vertex_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Turns one (row, column) grid point of a UV sphere into its vertex: position
// (also the normal), texture coordinates and the four quad-corner indices.
// ----------------------------------------------------------------------------
// One beat enters and one result beat leaves per cycle unless the output
// stalls. A beat passes the entry, divider integer-step, 32 one-bit divider,
// rounding, CORDIC fold, 24 rotation, map, multiply and output registers.
// The whole pipeline moves as one: it advances whenever the output register
// is empty or its beat is being taken, so a stall at the output holds every
// stage and nothing is lost or repeated. The segment registers are read live
// by the entry and divider stages and must only be written while the block
// is empty. Segment counts of zero are used as one and counts above
// MAX_SEGMENTS as MAX_SEGMENTS; rows and columns beyond the counts are clamped.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS  = uvs_pkg::DEF_MAX_SEGMENTS,
    parameter int FRACTION_BITS = uvs_pkg::DEF_FRACTION_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [uvs_pkg::APB_AW-1:0]   paddr,
    input  wire  [uvs_pkg::APB_DW-1:0]   pwdata,
    output logic [uvs_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // Grid point input
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [uvs_pkg::SEG_W-1:0]    i_row,
    input  wire  [uvs_pkg::SEG_W-1:0]    i_col,
    // Vertex output
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [uvs_pkg::POS_W-1:0]    o_pos_x,
    output logic [uvs_pkg::POS_W-1:0]    o_pos_y,
    output logic [uvs_pkg::POS_W-1:0]    o_pos_z,
    output logic [uvs_pkg::TEX_W-1:0]    o_tex_u,
    output logic [uvs_pkg::TEX_W-1:0]    o_tex_v,
    output logic                         o_face_valid,
    output logic [uvs_pkg::IDX_W-1:0]    o_corner_a,
    output logic [uvs_pkg::IDX_W-1:0]    o_corner_b,
    output logic [uvs_pkg::IDX_W-1:0]    o_corner_c,
    output logic [uvs_pkg::IDX_W-1:0]    o_corner_d
);
    import uvs_pkg::*;

    // Stage map: 0 entry, 1..34 divider, 35..60 CORDIC, 61 multiply, 62 output.
    localparam int DIV_LAT = DIV_STEPS + 2;
    localparam int COR_LAT = CORDIC_STEPS + 2;
    localparam int MUL_ST  = DIV_LAT + COR_LAT + 1;
    localparam int OUT_ST  = MUL_ST + 1;
    localparam int TEX_LEN = COR_LAT + 1;

    // ---------------- configuration registers ----------------
    logic [SEG_W-1:0] r_x_seg, r_y_seg;
    logic             w_cfg_wr;
    t_reg_idx         w_reg;

    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_seg <= SEG_W'(32);
            r_y_seg <= SEG_W'(16);
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_X_SEGMENTS: r_x_seg <= pwdata[SEG_W-1:0];
                REG_Y_SEGMENTS: r_y_seg <= pwdata[SEG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_X_SEGMENTS: prdata = APB_DW'(r_x_seg);
            REG_Y_SEGMENTS: prdata = APB_DW'(r_y_seg);
            default:        prdata = '0;
        endcase
    end

    // Segment counts as used: zero reads as one, large counts are capped.
    logic [SEG_W-1:0] w_xs, w_ys;
    always_comb begin
        w_xs = r_x_seg;
        w_ys = r_y_seg;
        if (r_x_seg == '0) w_xs = SEG_W'(1);
        else if (int'(r_x_seg) > MAX_SEGMENTS) w_xs = SEG_W'(MAX_SEGMENTS);
        if (r_y_seg == '0) w_ys = SEG_W'(1);
        else if (int'(r_y_seg) > MAX_SEGMENTS) w_ys = SEG_W'(MAX_SEGMENTS);
    end

    // ---------------- pipeline control ----------------
    logic [OUT_ST:0] r_vld;
    logic            w_en;

    assign w_en    = !r_vld[OUT_ST] || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_vld[OUT_ST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[OUT_ST-1:0], i_valid};
        end
    end

    // ---------------- entry stage ----------------
    logic [SEG_W-1:0] n_rr, n_cc;
    logic [SEG_W:0]   n_w;
    logic [19:0]      n_rw;
    t_side            n_side;

    always_comb begin
        n_rr = (i_row > w_ys) ? w_ys : i_row;
        n_cc = (i_col > w_xs) ? w_xs : i_col;
        n_w  = {1'b0, w_xs} + 1'b1;
        n_rw = 20'(n_rr) * 20'(n_w);
        n_side.face_valid = (n_rr < w_ys) && (n_cc < w_xs);
        n_side.corner_b   = IDX_W'(n_rw + 20'(n_cc));
        n_side.corner_c   = n_side.corner_b + 1'b1;
        n_side.corner_a   = n_side.corner_b + IDX_W'(n_w);
        n_side.corner_d   = n_side.corner_a + 1'b1;
    end

    logic [SEG_W-1:0] r_rr, r_cc;
    t_side            r_side [0:MUL_ST];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rr      <= n_rr;
            r_cc      <= n_cc;
            r_side[0] <= n_side;
        end
    end

    for (genvar k = 1; k <= MUL_ST; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_en) r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- dividers ----------------
    logic [ANG_W-1:0] w_theta, w_phi;
    logic [TEX_W-1:0] w_tex_u, w_tex_v;
    t_tex             w_tex;

    uvs_divider #(
        .ANGLE_BITS (ANG_W),
        .FRAC_BITS  (FRACTION_BITS)
    ) u_div_col (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_seg   (w_xs),
        .i_num   (r_cc),
        .o_angle (w_theta),
        .o_tex   (w_tex_u)
    );

    uvs_divider #(
        .ANGLE_BITS (ANG_W - 1),
        .FRAC_BITS  (FRACTION_BITS)
    ) u_div_row (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_seg   (w_ys),
        .i_num   (r_rr),
        .o_angle (w_phi),
        .o_tex   (w_tex_v)
    );

    assign w_tex = '{tex_u: w_tex_u, tex_v: w_tex_v};

    // Texture coordinates ride alongside the CORDIC and multiply stages.
    t_tex r_tex [0:TEX_LEN-1];
    always_ff @(posedge i_clk) begin
        if (w_en) r_tex[0] <= w_tex;
    end
    for (genvar k = 1; k < TEX_LEN; k++) begin : g_tex
        always_ff @(posedge i_clk) begin
            if (w_en) r_tex[k] <= r_tex[k-1];
        end
    end

    // ---------------- sine and cosine ----------------
    logic signed [TRIG_W-1:0] w_ct, w_st, w_cp, w_sp;

    uvs_cordic u_cor_theta (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_theta),
        .o_cos   (w_ct),
        .o_sin   (w_st)
    );

    uvs_cordic u_cor_phi (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_phi),
        .o_cos   (w_cp),
        .o_sin   (w_sp)
    );

    // ---------------- multiply stage ----------------
    logic signed [PROD_W-1:0] r_px, r_pz;
    logic signed [TRIG_W-1:0] r_cp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= PROD_W'(w_ct) * PROD_W'(w_sp);
            r_pz <= PROD_W'(w_st) * PROD_W'(w_sp);
            r_cp <= w_cp;
        end
    end

    // ---------------- round, saturate and output ----------------
    logic signed [PROD_W-1:0] n_rx, n_ry, n_rz;
    always_comb begin
        n_rx = (r_px + (64'sd1 <<< 44)) >>> 45;
        n_rz = (r_pz + (64'sd1 <<< 44)) >>> 45;
        n_ry = (PROD_W'(r_cp) + 64'sd16384) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_pos_x      <= sat_q15(n_rx);
            o_pos_y      <= sat_q15(n_ry);
            o_pos_z      <= sat_q15(n_rz);
            o_tex_u      <= r_tex[TEX_LEN-1].tex_u;
            o_tex_v      <= r_tex[TEX_LEN-1].tex_v;
            o_face_valid <= r_side[MUL_ST].face_valid;
            o_corner_a   <= r_side[MUL_ST].corner_a;
            o_corner_b   <= r_side[MUL_ST].corner_b;
            o_corner_c   <= r_side[MUL_ST].corner_c;
            o_corner_d   <= r_side[MUL_ST].corner_d;
        end
    end

    // ---------------- assertions ----------------
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted beat did not enter the entry stage");

    a_corner_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_corner_c == o_corner_b + 1'b1) && (o_corner_d == o_corner_a + 1'b1))
        else $error("quad corners are not adjacent");

endmodule : uv_sphere_vertex_generator
`default_nettype wire

FILE: hw/rtl/uvs_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_divider
// Pipelined restoring divider, one quotient bit per stage. Gives the rounded
// binary angle num*2^ANGLE_BITS/seg and the rounded texture coordinate
// num*2^FRAC_BITS/seg (round half up).
// ----------------------------------------------------------------------------
module uvs_divider #(
    parameter int ANGLE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire  [uvs_pkg::SEG_W-1:0]  i_seg,
    input  wire  [uvs_pkg::SEG_W-1:0]  i_num,
    output logic [uvs_pkg::ANG_W-1:0]  o_angle,
    output logic [uvs_pkg::TEX_W-1:0]  o_tex
);
    import uvs_pkg::*;

    logic [SEG_W-1:0] r_rem [0:DIV_STEPS];
    logic [ANG_W-1:0] r_quo [0:DIV_STEPS];
    logic [SEG_W-1:0] r_arem [ANGLE_BITS:DIV_STEPS];
    logic [ANG_W-1:0] r_aquo [ANGLE_BITS:DIV_STEPS];
    logic [SEG_W-1:0] r_trem [FRAC_BITS:DIV_STEPS];
    logic [TEX_W-1:0] r_tquo [FRAC_BITS:DIV_STEPS];

    logic [SEG_W-1:0] w_half;
    assign w_half = i_seg >> 1;

    // Integer step: the numerator never exceeds the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_num >= i_seg) begin
                r_rem[0] <= i_num - i_seg;
                r_quo[0] <= {{(ANG_W-1){1'b0}}, 1'b1};
            end else begin
                r_rem[0] <= i_num;
                r_quo[0] <= '0;
            end
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
        logic [SEG_W:0]   n_two;
        logic             n_bit;
        logic [SEG_W-1:0] n_rem;
        logic [ANG_W-1:0] n_quo;

        always_comb begin
            n_two = {r_rem[j-1], 1'b0};
            n_bit = (n_two >= {1'b0, i_seg});
            n_rem = n_bit ? SEG_W'(n_two - {1'b0, i_seg}) : n_two[SEG_W-1:0];
            n_quo = {r_quo[j-1][ANG_W-2:0], n_bit};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_quo[j] <= n_quo;
            end
        end

        if (j == ANGLE_BITS) begin : g_acap
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_arem[j] <= n_rem;
                    r_aquo[j] <= n_quo;
                end
            end
        end else if (j > ANGLE_BITS) begin : g_ahold
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_arem[j] <= r_arem[j-1];
                    r_aquo[j] <= r_aquo[j-1];
                end
            end
        end

        if (j == FRAC_BITS) begin : g_tcap
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_trem[j] <= n_rem;
                    r_tquo[j] <= n_quo[TEX_W-1:0];
                end
            end
        end else if (j > FRAC_BITS) begin : g_thold
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_trem[j] <= r_trem[j-1];
                    r_tquo[j] <= r_tquo[j-1];
                end
            end
        end
    end

    // Rounding: add one when remainder plus half the divisor reaches the divisor.
    logic n_aup, n_tup;
    always_comb begin
        n_aup = ({1'b0, r_arem[DIV_STEPS]} + {1'b0, w_half}) >= {1'b0, i_seg};
        n_tup = ({1'b0, r_trem[DIV_STEPS]} + {1'b0, w_half}) >= {1'b0, i_seg};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= r_aquo[DIV_STEPS] + ANG_W'(n_aup);
            o_tex   <= r_tquo[DIV_STEPS] + TEX_W'(n_tup);
        end
    end

endmodule : uvs_divider
`default_nettype wire

FILE: hw/rtl/uvs_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation-mode CORDIC: binary angle in, Q.30 cosine and sine out.
// One quadrant-fold stage, one stage per rotation, one quadrant-map stage.
// ----------------------------------------------------------------------------
module uvs_cordic (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire         [uvs_pkg::ANG_W-1:0]    i_angle,
    output logic signed [uvs_pkg::TRIG_W-1:0]   o_cos,
    output logic signed [uvs_pkg::TRIG_W-1:0]   o_sin
);
    import uvs_pkg::*;

    logic signed [32:0] r_x [0:CORDIC_STEPS];
    logic signed [32:0] r_y [0:CORDIC_STEPS];
    logic signed [31:0] r_z [0:CORDIC_STEPS];
    logic        [1:0]  r_q [0:CORDIC_STEPS];

    // The low 30 bits read as signed give the residual around the rounded quadrant.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= 32'(signed'(i_angle[29:0]));
            r_q[0] <= i_angle[31:30] + {1'b0, i_angle[29]};
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [32:0] n_dx, n_dy;
        logic signed [31:0] n_a;
        always_comb begin
            n_dx = r_y[i] >>> i;
            n_dy = r_x[i] >>> i;
            n_a  = signed'(ANGLE_TABLE[i]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - n_dx;
                    r_y[i+1] <= r_y[i] + n_dy;
                    r_z[i+1] <= r_z[i] - n_a;
                end else begin
                    r_x[i+1] <= r_x[i] + n_dx;
                    r_y[i+1] <= r_y[i] - n_dy;
                    r_z[i+1] <= r_z[i] + n_a;
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    logic signed [32:0] w_x, w_y;
    assign w_x = r_x[CORDIC_STEPS];
    assign w_y = r_y[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[CORDIC_STEPS])
                2'd0: begin
                    o_cos <= w_x[TRIG_W-1:0];
                    o_sin <= w_y[TRIG_W-1:0];
                end
                2'd1: begin
                    o_cos <= TRIG_W'(-w_y);
                    o_sin <= w_x[TRIG_W-1:0];
                end
                2'd2: begin
                    o_cos <= TRIG_W'(-w_x);
                    o_sin <= TRIG_W'(-w_y);
                end
                default: begin
                    o_cos <= w_y[TRIG_W-1:0];
                    o_sin <= TRIG_W'(-w_x);
                end
            endcase
        end
    end

endmodule : uvs_cordic
`default_nettype wire

FILE: bench/uv_sphere_vertex_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_test
// Drives grid points through the UV sphere vertex generator under several
// segment settings, with random bursts at the input and random stalls at the
// output. Every vertex beat is checked field by field against a bit-exact
// fixed-point model of the sphere held in a small scoreboard.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_test;

    import uvs_pkg::*;

    // Expected contents of one vertex beat.
    typedef struct {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             face_valid;
        logic [IDX_W-1:0] corner_a;
        logic [IDX_W-1:0] corner_b;
        logic [IDX_W-1:0] corner_c;
        logic [IDX_W-1:0] corner_d;
    } t_vertex;

    // The scoreboard holds its own copy of the segment registers and the
    // queue of vertices still owed by the block.
    class vertex_scoreboard;
        logic [SEG_W-1:0] x_seg;
        logic [SEG_W-1:0] y_seg;
        t_vertex          pending[$];
        int               mismatches;

        function void reset_regs();
            x_seg = 9'd32;
            y_seg = 9'd16;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function longint unsigned clamp_seg(logic [SEG_W-1:0] s);
            longint unsigned r;
            r = s;
            if (r < 1) r = 1;
            if (r > 256) r = 256;
            return r;
        endfunction

        // Quadrant fold followed by 24 CORDIC rotations; all shifts floor.
        function void trig(input logic [31:0] angle, output longint c,
                           output longint s);
            logic [1:0] quad;
            longint     z, x, y, dx, dy;
            quad = angle[31:30];
            z = longint'(angle & 32'h3FFF_FFFF);
            x = longint'(CORDIC_GAIN);
            y = 0;
            if (z >= 64'sh2000_0000) begin
                quad = quad + 2'd1;
                z = z - 64'sh4000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - longint'(ANGLE_TABLE[i]);
                end else begin
                    x = x + dx; y = y - dy; z = z + longint'(ANGLE_TABLE[i]);
                end
            end
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function logic [POS_W-1:0] round_q15(longint v, int shift);
            longint r;
            r = (v + (longint'(1) <<< (shift - 1))) >>> shift;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[POS_W-1:0];
        endfunction

        // Work out the vertex for one accepted grid point.
        function void note_point(logic [SEG_W-1:0] row, logic [SEG_W-1:0] col);
            longint unsigned xs, ys, rr, cc, w;
            logic [31:0]     theta, phi;
            longint          ct, st, cp, sp;
            t_vertex         v;
            xs = clamp_seg(x_seg);
            ys = clamp_seg(y_seg);
            rr = row;
            cc = col;
            if (rr > ys) rr = ys;
            if (cc > xs) cc = xs;
            w = xs + 1;
            theta = 32'(((cc << 32) + xs / 2) / xs);
            phi   = 32'(((rr << 31) + ys / 2) / ys);
            trig(theta, ct, st);
            trig(phi, cp, sp);
            v.pos_x      = round_q15(ct * sp, 45);
            v.pos_y      = round_q15(cp, 15);
            v.pos_z      = round_q15(st * sp, 45);
            v.tex_u      = TEX_W'(((cc << 16) + xs / 2) / xs);
            v.tex_v      = TEX_W'(((rr << 16) + ys / 2) / ys);
            v.face_valid = (rr < ys) && (cc < xs);
            v.corner_a   = IDX_W'((rr + 1) * w + cc);
            v.corner_b   = IDX_W'(rr * w + cc);
            v.corner_c   = IDX_W'(rr * w + cc + 1);
            v.corner_d   = IDX_W'((rr + 1) * w + cc + 1);
            pending.push_back(v);
        endfunction

        // Compare one vertex beat with the oldest expected vertex.
        task check_vertex(t_vertex got);
            t_vertex e;
            if (pending.size() == 0) begin
                report("vertex beat with nothing expected");
            end else begin
                e = pending.pop_front();
                if (got.pos_x !== e.pos_x)
                    report($sformatf("pos_x %h want %h", got.pos_x, e.pos_x));
                if (got.pos_y !== e.pos_y)
                    report($sformatf("pos_y %h want %h", got.pos_y, e.pos_y));
                if (got.pos_z !== e.pos_z)
                    report($sformatf("pos_z %h want %h", got.pos_z, e.pos_z));
                if (got.tex_u !== e.tex_u)
                    report($sformatf("tex_u %h want %h", got.tex_u, e.tex_u));
                if (got.tex_v !== e.tex_v)
                    report($sformatf("tex_v %h want %h", got.tex_v, e.tex_v));
                if (got.face_valid !== e.face_valid)
                    report($sformatf("face_valid %b want %b", got.face_valid,
                                     e.face_valid));
                if (got.corner_a !== e.corner_a)
                    report($sformatf("corner_a %h want %h", got.corner_a, e.corner_a));
                if (got.corner_b !== e.corner_b)
                    report($sformatf("corner_b %h want %h", got.corner_b, e.corner_b));
                if (got.corner_c !== e.corner_c)
                    report($sformatf("corner_c %h want %h", got.corner_c, e.corner_c));
                if (got.corner_d !== e.corner_d)
                    report($sformatf("corner_d %h want %h", got.corner_d, e.corner_d));
            end
        endtask
    endclass

    // The pipeline is 63 stages deep; give it some slack on top.
    localparam int DRAIN_CYCLES = 80;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               i_valid;
    logic               o_stall;
    logic [SEG_W-1:0]   i_row;
    logic [SEG_W-1:0]   i_col;
    logic               o_valid;
    logic               i_stall;
    logic [POS_W-1:0]   o_pos_x;
    logic [POS_W-1:0]   o_pos_y;
    logic [POS_W-1:0]   o_pos_z;
    logic [TEX_W-1:0]   o_tex_u;
    logic [TEX_W-1:0]   o_tex_v;
    logic               o_face_valid;
    logic [IDX_W-1:0]   o_corner_a;
    logic [IDX_W-1:0]   o_corner_b;
    logic [IDX_W-1:0]   o_corner_c;
    logic [IDX_W-1:0]   o_corner_d;

    vertex_scoreboard sb;
    bit               stall_enable;

    uv_sphere_vertex_generator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_tex_u      (o_tex_u),
        .o_tex_v      (o_tex_v),
        .o_face_valid (o_face_valid),
        .o_corner_a   (o_corner_a),
        .o_corner_b   (o_corner_b),
        .o_corner_c   (o_corner_c),
        .o_corner_d   (o_corner_d)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver stalls on a pattern of its own: now and then, by a random draw,
    // it switches to a mode of no stalls, light random stalls, or heavy random stalls.
    initial begin
        int mode;
        i_stall = 1'b0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(63, 0) == 0) mode = $urandom_range(2, 0);
            if (!stall_enable || mode == 0) i_stall <= 1'b0;
            else if (mode == 1) i_stall <= ($urandom_range(3, 0) == 0);
            else i_stall <= ($urandom_range(9, 0) < 8);
        end
    end

    // Every vertex beat taken at a rising edge goes to the scoreboard.
    always @(posedge i_clk) begin
        t_vertex got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.pos_x      = o_pos_x;
            got.pos_y      = o_pos_y;
            got.pos_z      = o_pos_z;
            got.tex_u      = o_tex_u;
            got.tex_v      = o_tex_v;
            got.face_valid = o_face_valid;
            got.corner_a   = o_corner_a;
            got.corner_b   = o_corner_b;
            got.corner_c   = o_corner_c;
            got.corner_d   = o_corner_d;
            sb.check_vertex(got);
        end
    end

    // Register write with setup and access phases; pready is always high so the
    // access cycle completes at the following rising edge.
    task write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_X_SEGMENTS) sb.x_seg = value[SEG_W-1:0];
        else sb.y_seg = value[SEG_W-1:0];
    endtask

    // Present one grid point and hold it until the block takes the beat.
    // Valid is left high so back-to-back beats need no extra edge.
    task send_point(logic [SEG_W-1:0] row, logic [SEG_W-1:0] col);
        i_valid <= 1'b1;
        i_row   <= row;
        i_col   <= col;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_point(row, col);
        @(negedge i_clk);
    endtask

    task idle_cycles(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
            i_row <= 9'($urandom);
            i_col <= 9'($urandom);
            @(negedge i_clk);
        end
    endtask

    // Wait until every owed vertex has come out, then let the pipeline
    // settle so that a register write cannot catch a beat in flight.
    task drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One phase: grid corners and fixed points first, then random points sent in
    // bursts. Most points lie on or just past the grid; a few use the full
    // input range to exercise clamping and every input bit.
    task run_phase(int n_random);
        int xs, ys, burst;
        xs = int'(sb.clamp_seg(sb.x_seg));
        ys = int'(sb.clamp_seg(sb.y_seg));
        send_point(9'd0, 9'd0);
        send_point(SEG_W'(ys), SEG_W'(xs));
        send_point(SEG_W'(ys), 9'd0);
        send_point(9'd0, SEG_W'(xs));
        send_point(SEG_W'(ys / 2), SEG_W'(xs / 4));
        send_point(9'h1FF, 9'h1FF);
        send_point(9'h155, 9'h0AA);
        send_point(9'h0AA, 9'h155);
        while (n_random > 0) begin
            burst = $urandom_range(20, 1);
            for (int k = 0; k < burst && n_random > 0; k++) begin
                if ($urandom_range(9, 0) == 0)
                    send_point(9'($urandom), 9'($urandom));
                else
                    send_point(SEG_W'($urandom_range(ys + 1, 0)),
                               SEG_W'($urandom_range(xs + 1, 0)));
                n_random--;
            end
            if ($urandom_range(3, 0) != 0) idle_cycles($urandom_range(6, 1));
        end
        drain();
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        stall_enable = 1'b0;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_valid = 1'b0;
        i_row   = '0;
        i_col   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        stall_enable = 1'b1;

        // Reset settings first, then the extremes, out-of-range register
        // values that the block clamps, and a few odd sizes.
        run_phase(256);
        write_reg(REG_X_SEGMENTS, 32'd1);
        write_reg(REG_Y_SEGMENTS, 32'd1);
        run_phase(150);
        write_reg(REG_X_SEGMENTS, 32'd256);
        write_reg(REG_Y_SEGMENTS, 32'd256);
        run_phase(160);
        write_reg(REG_X_SEGMENTS, 32'd0);
        write_reg(REG_Y_SEGMENTS, 32'd0);
        run_phase(120);
        write_reg(REG_X_SEGMENTS, 32'h1FF);
        write_reg(REG_Y_SEGMENTS, 32'd300);
        run_phase(150);
        write_reg(REG_X_SEGMENTS, 32'd3);
        write_reg(REG_Y_SEGMENTS, 32'd5);
        run_phase(150);
        write_reg(REG_X_SEGMENTS, 32'd7);
        write_reg(REG_Y_SEGMENTS, 32'd255);
        run_phase(150);
        write_reg(REG_X_SEGMENTS, 32'($urandom_range(256, 2)));
        write_reg(REG_Y_SEGMENTS, 32'($urandom_range(256, 2)));
        run_phase(150);

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("uv_sphere_vertex_generator test passed");
        end else begin
            $display("uv_sphere_vertex_generator test failed");
        end
        $finish;
    end

    // A run that has not finished by this time is reported as failed.
    initial begin
        #2ms;
        $display("uv_sphere_vertex_generator test failed");
        $finish;
    end

endmodule
